// ----- rtl/core/brfo_pkg.sv -----
package brfo_pkg;

  // Physical store depth and the longest burst or byte count honored.
  localparam int DEPTH     = 256;
  localparam int MAX_BURST = 64;

  // The ring never uses more than 256 slots, whatever the store depth.
  localparam int RING_MAX = (DEPTH < 256) ? DEPTH : 256;
  localparam int IDX_W    = $clog2(RING_MAX);
  localparam int RLEN_W   = 9;
  localparam int CNT_W    = 8;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;

  typedef enum logic [2:0] {
    CMD_GUARDED_WR = 3'd0,
    CMD_OVERWR_WR  = 3'd1,
    CMD_READ       = 3'd2,
    CMD_READ_UPTO  = 3'd3,
    CMD_PEEK       = 3'd4,
    CMD_DISCARD    = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_STATUS     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_DATA  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_STREAM = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic cfg_wr;
    logic single;
    logic start;
    logic step;
    logic busy;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic multi;
    logic slot_free;
    logic last_beat;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx,
                                                input logic [RLEN_W-1:0] rlen);
    logic [RLEN_W-1:0] n;
    n = RLEN_W'(idx) + RLEN_W'(1);
    return (n >= rlen) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/brfo_ram.sv -----
module brfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/brfo_ctrl.sv -----
module brfo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  brfo_pkg::dp_stat_t    stat,
  output brfo_pkg::ctrl_cmd_t   cmd
);

  brfo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brfo_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brfo_pkg::S_IDLE: begin
        if (in_tvalid && stat.slot_free && !cfg_valid && stat.multi) begin
          state_nxt = brfo_pkg::S_STREAM;
        end
      end
      brfo_pkg::S_STREAM: begin
        if (stat.slot_free && stat.last_beat) begin
          state_nxt = brfo_pkg::S_IDLE;
        end
      end
      default: state_nxt = brfo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    cmd       = '0;
    case (state_r)
      brfo_pkg::S_IDLE: begin
        // Configuration wins over a command offered in the same cycle.
        cfg_ready  = 1'b1;
        in_tready  = stat.slot_free && !cfg_valid;
        cmd.cfg_wr = cfg_valid;
        cmd.start  = in_tvalid && in_tready && stat.multi;
        cmd.single = in_tvalid && in_tready && !stat.multi;
      end
      brfo_pkg::S_STREAM: begin
        cmd.busy = 1'b1;
        cmd.step = stat.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/brfo_dp.sv -----
module brfo_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic [8:0]            cfg_data,
  output logic [31:0]           out_tdata,
  output logic [2:0]            out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  brfo_pkg::ctrl_cmd_t   cmd,
  output brfo_pkg::dp_stat_t    stat
);

  localparam int IW = brfo_pkg::IDX_W;
  localparam int RW = brfo_pkg::RLEN_W;
  localparam int CW = brfo_pkg::CNT_W;
  localparam int LW = brfo_pkg::LEN_W;
  localparam int BW = brfo_pkg::BYTE_W;

  brfo_pkg::cmd_t in_cmd;
  logic [BW-1:0]  in_byte;
  logic [LW-1:0]  in_len, n_sat, n_eff;

  logic [RW-1:0] rlen_r, rlen_nxt;
  logic [IW-1:0] wi_r, wi_nxt, ri_r, ri_nxt, cur_r, cur_nxt;
  logic [CW-1:0] fill_r, fill_nxt, hw_r, hw_nxt;
  logic [LW-1:0] brem_r, brem_nxt, rem_r, rem_nxt;
  logic          brej_r, brej_nxt, pop_r, pop_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] obyte_r, obyte_nxt;
  logic          obv_r, obv_nxt, olast_r, olast_nxt;
  brfo_pkg::status_t ost_r, ost_nxt;
  logic [CW-1:0] ofill_r, ofill_nxt, ofree_r, ofree_nxt, omax_r, omax_nxt;

  logic [RW-1:0] freec, free_after, ri_sum, cfg_len;
  logic [CW:0]   fill_inc;
  logic          ram_we, store;
  logic [IW-1:0] raddr;
  logic [BW-1:0] rdata;
  logic [LW-1:0] n1;
  brfo_pkg::status_t st_single;

  assign in_cmd  = brfo_pkg::cmd_t'(in_tuser);
  assign in_byte = in_tdata[7:0];
  assign in_len  = in_tdata[14:8];
  assign n_sat   = (in_len > LW'(brfo_pkg::MAX_BURST)) ? LW'(brfo_pkg::MAX_BURST) : in_len;

  // Read-up-to clamps its count to what is stored.
  assign n_eff = ((in_cmd == brfo_pkg::CMD_READ_UPTO) && (CW'(n_sat) > fill_r)) ?
                 fill_r[LW-1:0] : n_sat;

  assign freec    = rlen_r - RW'(1) - RW'(fill_r);
  assign fill_inc = (CW+1)'(fill_r) + (CW+1)'(1);
  assign n1       = (n_sat == '0) ? LW'(1) : n_sat;
  assign ri_sum   = RW'(ri_r) + RW'(n_sat);
  assign cfg_len  = (cfg_data < RW'(2)) ? RW'(2) :
                    (cfg_data > RW'(brfo_pkg::RING_MAX)) ? RW'(brfo_pkg::RING_MAX) : cfg_data;

  always_comb begin
    stat.slot_free = !out_valid_r || out_tready;
    stat.last_beat = (rem_r == LW'(1));
    case (in_cmd)
      brfo_pkg::CMD_READ, brfo_pkg::CMD_READ_UPTO, brfo_pkg::CMD_PEEK:
        stat.multi = (n_eff != '0) && (CW'(n_eff) <= fill_r);
      default: stat.multi = 1'b0;
    endcase
  end

  // Next state of the ring bookkeeping.
  always_comb begin
    rlen_nxt  = rlen_r;
    wi_nxt    = wi_r;
    ri_nxt    = ri_r;
    cur_nxt   = cur_r;
    fill_nxt  = fill_r;
    hw_nxt    = hw_r;
    brem_nxt  = brem_r;
    brej_nxt  = brej_r;
    rem_nxt   = rem_r;
    pop_nxt   = pop_r;
    ram_we    = 1'b0;
    store     = 1'b0;
    st_single = brfo_pkg::ST_OK;

    if (cmd.cfg_wr) begin
      rlen_nxt = cfg_len;
      wi_nxt   = '0;
      ri_nxt   = '0;
      fill_nxt = '0;
      brem_nxt = '0;
      brej_nxt = 1'b0;
    end else if (cmd.single) begin
      case (in_cmd)
        brfo_pkg::CMD_GUARDED_WR: begin
          if ((n_sat == '0) && (brem_r != '0)) begin
            brem_nxt = brem_r - LW'(1);
            if (brej_r || (freec == '0)) begin
              st_single = brfo_pkg::ST_FULL;
            end else begin
              store = 1'b1;
            end
            if (brem_nxt == '0) begin
              brej_nxt = 1'b0;
            end
          end else begin
            brem_nxt = n1 - LW'(1);
            if (RW'(n1) > freec) begin
              brej_nxt  = (n1 != LW'(1));
              st_single = brfo_pkg::ST_FULL;
            end else begin
              brej_nxt = 1'b0;
              store    = 1'b1;
            end
          end
          if (store) begin
            ram_we   = 1'b1;
            wi_nxt   = brfo_pkg::ring_adv(wi_r, rlen_r);
            fill_nxt = fill_inc[CW-1:0];
            if (fill_inc[CW-1:0] > hw_r) begin
              hw_nxt = fill_inc[CW-1:0];
            end
          end
        end
        brfo_pkg::CMD_OVERWR_WR: begin
          ram_we = 1'b1;
          wi_nxt = brfo_pkg::ring_adv(wi_r, rlen_r);
          if (freec == '0) begin
            // Full: the oldest byte makes room.
            ri_nxt = brfo_pkg::ring_adv(ri_r, rlen_r);
          end else begin
            fill_nxt = fill_inc[CW-1:0];
          end
        end
        brfo_pkg::CMD_READ, brfo_pkg::CMD_READ_UPTO, brfo_pkg::CMD_PEEK: begin
          if (CW'(n_eff) > fill_r) begin
            st_single = brfo_pkg::ST_NO_DATA;
          end
        end
        brfo_pkg::CMD_DISCARD: begin
          if (CW'(n_sat) > fill_r) begin
            st_single = brfo_pkg::ST_NO_DATA;
          end else begin
            ri_nxt   = (ri_sum >= rlen_r) ? IW'(ri_sum - rlen_r) : ri_sum[IW-1:0];
            fill_nxt = fill_r - CW'(n_sat);
          end
        end
        brfo_pkg::CMD_CLEAR: begin
          wi_nxt   = '0;
          ri_nxt   = '0;
          fill_nxt = '0;
          brem_nxt = '0;
          brej_nxt = 1'b0;
        end
        default: begin
          st_single = brfo_pkg::ST_OK;
        end
      endcase
    end else if (cmd.start) begin
      cur_nxt = ri_r;
      rem_nxt = n_eff;
      pop_nxt = (in_cmd != brfo_pkg::CMD_PEEK);
    end else if (cmd.step) begin
      cur_nxt = brfo_pkg::ring_adv(cur_r, rlen_r);
      rem_nxt = rem_r - LW'(1);
      if (pop_r) begin
        ri_nxt   = cur_nxt;
        fill_nxt = fill_r - CW'(1);
      end
    end
  end

  // The store is read ahead: rdata always holds the byte at the cursor.
  always_comb begin
    if (cmd.step) begin
      raddr = brfo_pkg::ring_adv(cur_r, rlen_r);
    end else if (cmd.busy) begin
      raddr = cur_r;
    end else begin
      raddr = ri_r;
    end
  end

  assign free_after = rlen_r - RW'(1) - RW'(fill_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    obyte_nxt     = obyte_r;
    obv_nxt       = obv_r;
    ost_nxt       = ost_r;
    olast_nxt     = olast_r;
    ofill_nxt     = ofill_r;
    ofree_nxt     = ofree_r;
    omax_nxt      = omax_r;
    if (cmd.single || cmd.step) begin
      out_valid_nxt = 1'b1;
      obyte_nxt     = cmd.step ? rdata : '0;
      obv_nxt       = cmd.step;
      ost_nxt       = cmd.step ? brfo_pkg::ST_OK : st_single;
      olast_nxt     = cmd.single || stat.last_beat;
      ofill_nxt     = fill_nxt;
      ofree_nxt     = free_after[CW-1:0];
      omax_nxt      = hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlen_r      <= RW'(brfo_pkg::RING_MAX);
      wi_r        <= '0;
      ri_r        <= '0;
      fill_r      <= '0;
      hw_r        <= '0;
      brem_r      <= '0;
      brej_r      <= 1'b0;
      rem_r       <= '0;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rlen_r      <= rlen_nxt;
      wi_r        <= wi_nxt;
      ri_r        <= ri_nxt;
      fill_r      <= fill_nxt;
      hw_r        <= hw_nxt;
      brem_r      <= brem_nxt;
      brej_r      <= brej_nxt;
      rem_r       <= rem_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    obv_r   <= obv_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
    ofill_r <= ofill_nxt;
    ofree_r <= ofree_nxt;
    omax_r  <= omax_nxt;
  end

  brfo_ram #(
    .WIDTH (BW),
    .DEPTH (brfo_pkg::RING_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r),
    .wdata (in_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {omax_r, ofree_r, ofill_r, obyte_r};
  assign out_tuser  = {ost_r, obv_r};
  assign out_tlast  = olast_r;

endmodule

// ----- rtl/core/byte_ring_fifo_with_overwrite.sv -----
// Byte ring FIFO with guarded bursts and overwrite-oldest writes.
//
// Input stream: one command per beat. in_tuser carries the command code;
// in_tdata carries data_byte in [7:0] and length in [14:8].
// Output stream: one or more result beats per command, the final one with
// out_tlast set. Each beat reports the byte (if any), its status and the
// fill, free space and high watermark after that beat's action.
// cfg_data sets the ring length (clamped to 2..256); usable space is one less.
// Writing it empties the FIFO and cancels an open burst, watermark kept.
//
// A single-result command loads its beat into the output register at
// the edge that accepts it, so single-result commands run one per cycle
// while the output is not stalled. A read or peek of n bytes enters the
// streaming state on acceptance and then loads one byte per cycle from
// the store while the output is not stalled, read ahead through its
// registered port; in_tready stays low until the last byte is loaded.
// Reset leaves the FIFO empty, the ring at 256 and the watermark at zero;
// store contents are undefined until written. When the receiver stalls the
// output register holds its beat and in_tready stays low until it drains.
module byte_ring_fifo_with_overwrite (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], length[14:8], pad[15]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte, fill_count, free_count, max_fill
  output logic [2:0]  out_tuser,  // byte_valid[0], status[2:1]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  brfo_pkg::ctrl_cmd_t cmd;
  brfo_pkg::dp_stat_t  stat;

  brfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brfo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- rtl/core/brfo_checker.sv -----
module brfo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
    && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A beat carrying a byte always reports success.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == 2'd0)
    else $error("byte delivered with error status");

  // Beats without a byte are single-result commands, so they close the item.
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("non-data result not marked last");

  // Nothing is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind byte_ring_fifo_with_overwrite brfo_checker u_brfo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import brfo_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [1:0] status;
    logic       last;
    logic [7:0] fill;
    logic [7:0] room;
    logic [7:0] peak;
  } fifo_beat_t;

  // Tracks the ring contents and the burst bookkeeping, and holds the result
  // beats that each accepted command is due to produce.
  class fifo_scoreboard;
    fifo_beat_t  pending[$];
    logic [7:0]  mem[RING_MAX];
    int unsigned ring;
    int unsigned wptr;
    int unsigned rptr;
    int unsigned peak;
    int unsigned burst_left;
    bit          burst_drop;
    int          errors;

    function new();
      ring       = 256;
      wptr       = 0;
      rptr       = 0;
      peak       = 0;
      burst_left = 0;
      burst_drop = 0;
      errors     = 0;
    endfunction

    function int unsigned level();
      return (wptr >= rptr) ? wptr - rptr : ring - rptr + wptr;
    endfunction

    function int unsigned step_ptr(int unsigned p);
      return (p + 1 >= ring) ? 0 : p + 1;
    endfunction

    function void add_beat(logic [7:0] b, logic has, status_t st);
      fifo_beat_t beat;
      beat.data     = b;
      beat.has_byte = has;
      beat.status   = st;
      beat.last     = 1'b0;
      beat.fill     = 8'(level());
      beat.room     = 8'(ring - 1 - level());
      beat.peak     = 8'(peak);
      pending.push_back(beat);
    endfunction

    // Only bytes stored by guarded writes move the watermark.
    function void keep_guarded(logic [7:0] din);
      mem[wptr] = din;
      wptr = step_ptr(wptr);
      if (level() > peak) peak = level();
    endfunction

    function void apply_ring_size(logic [8:0] value);
      ring       = (value < 2) ? 2 : (value > RING_MAX) ? RING_MAX : value;
      wptr       = 0;
      rptr       = 0;
      burst_left = 0;
      burst_drop = 0;
    endfunction

    function void note_input(cmd_t op, logic [7:0] din, logic [6:0] len);
      int unsigned n;
      int unsigned lvl;
      int unsigned free_now;
      int unsigned p;
      n        = (len > MAX_BURST) ? MAX_BURST : len;
      lvl      = level();
      free_now = ring - 1 - lvl;
      case (op)
        CMD_GUARDED_WR: begin
          if (n == 0 && burst_left > 0) begin
            burst_left--;
            if (burst_drop || free_now == 0) begin
              add_beat(8'd0, 1'b0, ST_FULL);
            end else begin
              keep_guarded(din);
              add_beat(8'd0, 1'b0, ST_OK);
            end
            if (burst_left == 0) burst_drop = 0;
          end else begin
            // A zero length with no open burst acts as a one-byte burst.
            if (n == 0) n = 1;
            burst_left = n - 1;
            if (n > free_now) begin
              burst_drop = (burst_left > 0);
              add_beat(8'd0, 1'b0, ST_FULL);
            end else begin
              burst_drop = 0;
              keep_guarded(din);
              add_beat(8'd0, 1'b0, ST_OK);
            end
          end
        end
        CMD_OVERWR_WR: begin
          if (free_now == 0) rptr = step_ptr(rptr);
          mem[wptr] = din;
          wptr = step_ptr(wptr);
          add_beat(8'd0, 1'b0, ST_OK);
        end
        CMD_READ, CMD_READ_UPTO: begin
          if (op == CMD_READ_UPTO && n > lvl) n = lvl;
          if (n > lvl) begin
            add_beat(8'd0, 1'b0, ST_NO_DATA);
          end else if (n == 0) begin
            add_beat(8'd0, 1'b0, ST_OK);
          end else begin
            repeat (n) begin
              p = rptr;
              rptr = step_ptr(rptr);
              add_beat(mem[p], 1'b1, ST_OK);
            end
          end
        end
        CMD_PEEK: begin
          if (n > lvl) begin
            add_beat(8'd0, 1'b0, ST_NO_DATA);
          end else if (n == 0) begin
            add_beat(8'd0, 1'b0, ST_OK);
          end else begin
            p = rptr;
            repeat (n) begin
              add_beat(mem[p], 1'b1, ST_OK);
              p = step_ptr(p);
            end
          end
        end
        CMD_DISCARD: begin
          if (n > lvl) begin
            add_beat(8'd0, 1'b0, ST_NO_DATA);
          end else begin
            repeat (n) rptr = step_ptr(rptr);
            add_beat(8'd0, 1'b0, ST_OK);
          end
        end
        CMD_CLEAR: begin
          wptr       = 0;
          rptr       = 0;
          burst_left = 0;
          burst_drop = 0;
          add_beat(8'd0, 1'b0, ST_OK);
        end
        default: add_beat(8'd0, 1'b0, ST_OK);
      endcase
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(fifo_beat_t got);
      fifo_beat_t want;
      bit         bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing pending: byte %h valid %b status %0d",
                   $time, got.data, got.has_byte, got.status);
        return;
      end
      want = pending.pop_front();
      bad = (got.data !== want.data) || (got.has_byte !== want.has_byte) ||
            (got.status !== want.status) || (got.last !== want.last) ||
            (got.fill !== want.fill) || (got.room !== want.room) ||
            (got.peak !== want.peak);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected byte %h valid %b status %0d last %b fill %0d free %0d peak %0d",
                   want.data, want.has_byte, want.status, want.last, want.fill,
                   want.room, want.peak);
          $display("  actual   byte %h valid %b status %0d last %b fill %0d free %0d peak %0d",
                   got.data, got.has_byte, got.status, got.last, got.fill,
                   got.room, got.peak);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // data_byte[7:0], length[14:8], pad[15]
  logic [2:0]  in_tuser;   // command[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_byte, fill_count, free_count, max_fill
  logic [2:0]  out_tuser;  // byte_valid[0], status[2:1]
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  fifo_scoreboard sb = new();

  bit send_lazy;
  bit recv_lazy;
  bit hold_req;
  int items_sent;

  byte_ring_fifo_with_overwrite u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Valid is only dropped when a gap follows, so back-to-back beats keep it high
  // without a second assignment in the same step.
  task automatic send_item(cmd_t op, logic [7:0] din, logic [6:0] len);
    int gap;
    gap = send_lazy ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, len, din};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, din, len);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_ring(logic [8:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_ring_size(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly counts that the FIFO can serve, now and then anything the field holds.
  function automatic int pick_count(int unsigned lvl);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 127);
    return $urandom_range(0, (lvl < 16) ? lvl : 16);
  endfunction

  task automatic run_random(int budget);
    int stop_at;
    int kind;
    int n;
    int k;
    int unsigned lvl;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 11);
      lvl  = sb.level();
      case (kind)
        0, 1, 2, 3: begin
          n = $urandom_range(0, 9);
          if (n < 7) n = $urandom_range(1, 8);
          else if (n < 9) n = $urandom_range(9, 64);
          else n = $urandom_range(65, 127);
          send_item(CMD_GUARDED_WR, 8'($urandom), 7'(n));
          for (k = 1; k < n && k < MAX_BURST; k++) begin
            if ($urandom_range(0, 39) == 0) break;
            if ($urandom_range(0, 11) == 0)
              send_item(cmd_t'($urandom_range(1, 7)), 8'($urandom),
                        7'(pick_count(sb.level())));
            send_item(CMD_GUARDED_WR, 8'($urandom), 7'd0);
          end
        end
        4, 5: begin
          repeat ($urandom_range(1, 6))
            send_item(CMD_OVERWR_WR, 8'($urandom), 7'($urandom));
        end
        6, 7: send_item(CMD_READ, 8'($urandom), 7'(pick_count(lvl)));
        8:    send_item(CMD_READ_UPTO, 8'($urandom), 7'(pick_count(lvl + 4)));
        9:    send_item(CMD_PEEK, 8'($urandom), 7'(pick_count(lvl)));
        10:   send_item(CMD_DISCARD, 8'($urandom), 7'(pick_count(lvl)));
        default: send_item(cmd_t'($urandom_range(0, 7)), 8'($urandom), 7'($urandom));
      endcase
    end
  endtask

  initial begin : result_sink
    fifo_beat_t got;
    int         stall_left;
    int         hold_left;
    bit         hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.data     = out_tdata[7:0];
        got.fill     = out_tdata[15:8];
        got.room     = out_tdata[23:16];
        got.peak     = out_tdata[31:24];
        got.has_byte = out_tuser[0];
        got.status   = out_tuser[2:1];
        got.last     = out_tlast;
        sb.check_result(got);
        stall_left = recv_lazy ? $urandom_range(0, 13) : 0;
      end
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [8:0] ring_plan[8];
    int         i;
    ring_plan  = '{9'd511, 9'd2, 9'd0, 9'd9, 9'd64, 9'd1, 9'd256, 9'd130};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_STATUS;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    send_lazy  = 1;
    recv_lazy  = 1;
    hold_req   = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset ring of 256: empty reads, a saturated burst length, an abandoned
    // burst, a continuation with nothing open, then peek, read and discard.
    send_item(CMD_STATUS, 8'h00, 7'd0);
    send_item(CMD_READ, 8'h00, 7'd1);
    send_item(CMD_READ_UPTO, 8'h00, 7'd5);
    send_item(CMD_GUARDED_WR, 8'hff, 7'd127);
    send_item(CMD_GUARDED_WR, 8'h00, 7'd0);
    send_item(CMD_GUARDED_WR, 8'ha5, 7'd2);
    send_item(CMD_GUARDED_WR, 8'h5a, 7'd0);
    send_item(CMD_GUARDED_WR, 8'h80, 7'd0);
    send_item(CMD_PEEK, 8'h00, 7'd3);
    send_item(CMD_READ, 8'h00, 7'd2);
    send_item(CMD_DISCARD, 8'h00, 7'd5);
    send_item(CMD_DISCARD, 8'h00, 7'd1);
    send_item(CMD_READ, 8'h00, 7'd0);
    send_item(CMD_CLEAR, 8'h00, 7'd0);

    // Three-byte FIFO: a rejected burst, a burst that runs into a full FIFO
    // after overwrites, and overwrite dropping the oldest byte.
    set_ring(9'd4);
    send_item(CMD_GUARDED_WR, 8'h01, 7'd5);
    send_item(CMD_GUARDED_WR, 8'h02, 7'd0);
    send_item(CMD_GUARDED_WR, 8'h11, 7'd3);
    send_item(CMD_OVERWR_WR, 8'h22, 7'd0);
    send_item(CMD_OVERWR_WR, 8'h33, 7'd0);
    send_item(CMD_OVERWR_WR, 8'h44, 7'd0);
    send_item(CMD_GUARDED_WR, 8'h55, 7'd0);
    send_item(CMD_PEEK, 8'h00, 7'd9);
    send_item(CMD_PEEK, 8'h00, 7'd3);
    send_item(CMD_READ_UPTO, 8'h00, 7'd64);
    send_item(CMD_DISCARD, 8'h00, 7'd0);
    send_item(CMD_STATUS, 8'h00, 7'd0);

    for (i = 0; i < 8; i++) begin
      set_ring(ring_plan[i]);
      send_lazy = (i % 3 != 1);
      recv_lazy = (i % 4 != 1);
      // The receiver stops for a long stretch while commands keep coming.
      if (i == 0) hold_req = 1;
      run_random(42);
    end

    wait_drained();
    repeat (70) @(posedge clk);
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
